// ===== rtl/smft_pkg.sv =====
package smft_pkg;

  localparam int CMD_W  = 8;
  localparam int ADDR_W = 24;
  localparam int DATA_W = 32;
  localparam int RD_W   = 32;
  localparam int DIV_W  = 8;

  localparam int FRAME_BITS_DEF   = 64;
  localparam int READ_BITS_DEF    = 32;
  localparam int ADDRESS_BITS_DEF = 24;

  localparam logic [DIV_W-1:0] HALF_PERIOD_RST = 8'd5;
  localparam logic [CMD_W-1:0] CMD_WRITE       = 8'h00;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ENABLE = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_WAIT   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              start_req;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              miso_bit;
  } in_word_t;

  typedef struct packed {
    logic            chip_select_n;
    logic            serial_clock;
    logic            mosi_bit;
    logic            ready_res;
    logic [RD_W-1:0] read_data;
    logic            done_res;
  } out_word_t;

endpackage

// ===== rtl/smft_core.sv =====
module smft_core #(
  parameter int FRAME_BITS   = smft_pkg::FRAME_BITS_DEF,
  parameter int READ_BITS    = smft_pkg::READ_BITS_DEF,
  parameter int ADDRESS_BITS = smft_pkg::ADDRESS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [smft_pkg::DIV_W-1:0]     cfg_write_data,
  input  logic                           step,
  input  smft_pkg::in_word_t             in_word,
  output smft_pkg::out_word_t            result
);

  localparam int DATA_BITS  = FRAME_BITS - smft_pkg::CMD_W - ADDRESS_BITS;
  localparam int CMD_LSB    = FRAME_BITS - smft_pkg::CMD_W;
  localparam int BI_W       = $clog2(FRAME_BITS);
  localparam int READ_START = (READ_BITS >= FRAME_BITS) ? 0 : FRAME_BITS - READ_BITS;
  localparam logic [BI_W-1:0] READ_START_IDX = BI_W'(READ_START);
  localparam logic [BI_W-1:0] LAST_IDX       = BI_W'(FRAME_BITS - 1);

  logic [smft_pkg::DIV_W-1:0] half_period_r;
  smft_pkg::phase_t           phase_r, phase_nxt;
  logic [smft_pkg::DIV_W-1:0] div_r, div_nxt;
  logic                       sck_r, sck_nxt;
  logic [FRAME_BITS-1:0]      tx_r, tx_nxt;
  logic [BI_W-1:0]            bit_idx_r, bit_idx_nxt;
  logic [READ_BITS-1:0]       rx_r, rx_nxt;
  logic                       done;

  logic [FRAME_BITS-1:0]      frame;
  logic                       is_write;
  logic [smft_pkg::DIV_W-1:0] hp;
  logic                       div_end;

  assign is_write = (in_word.command == smft_pkg::CMD_WRITE);

  for (genvar i = 0; i < FRAME_BITS; i++) begin : g_frame
    if (i >= CMD_LSB) begin : g_cmd
      assign frame[i] = in_word.command[i - CMD_LSB];
    end else if (i >= DATA_BITS) begin : g_addr
      assign frame[i] = in_word.address[i - DATA_BITS];
    end else if (i < smft_pkg::DATA_W) begin : g_data
      assign frame[i] = is_write & in_word.write_data[i];
    end else begin : g_zero
      assign frame[i] = 1'b0;
    end
  end

  assign hp      = (half_period_r == '0) ? smft_pkg::DIV_W'(1) : half_period_r;
  assign div_end = ({1'b0, div_r} + 9'd1) >= {1'b0, hp};

  always_comb begin
    phase_nxt   = phase_r;
    div_nxt     = div_r;
    sck_nxt     = sck_r;
    tx_nxt      = tx_r;
    bit_idx_nxt = bit_idx_r;
    rx_nxt      = rx_r;
    done        = 1'b0;
    case (phase_r)
      smft_pkg::PH_IDLE: begin
        if (in_word.start_req) begin
          tx_nxt      = frame;
          bit_idx_nxt = '0;
          div_nxt     = '0;
          sck_nxt     = 1'b0;
          rx_nxt      = '0;
          phase_nxt   = smft_pkg::PH_ENABLE;
        end
      end
      smft_pkg::PH_ENABLE: begin
        div_nxt   = '0;
        sck_nxt   = 1'b0;
        phase_nxt = smft_pkg::PH_DATA;
      end
      smft_pkg::PH_DATA: begin
        if (div_end) begin
          div_nxt = '0;
          if (!sck_r) begin
            sck_nxt = 1'b1;
            if (bit_idx_r >= READ_START_IDX) begin
              rx_nxt = {rx_r[READ_BITS-2:0], in_word.miso_bit};
            end
          end else begin
            sck_nxt = 1'b0;
            tx_nxt  = {tx_r[FRAME_BITS-2:0], 1'b0};
            if (bit_idx_r == LAST_IDX) begin
              bit_idx_nxt = '0;
              phase_nxt   = smft_pkg::PH_WAIT;
            end else begin
              bit_idx_nxt = bit_idx_r + BI_W'(1);
            end
          end
        end else begin
          div_nxt = div_r + smft_pkg::DIV_W'(1);
        end
      end
      default: begin
        div_nxt   = '0;
        sck_nxt   = 1'b0;
        phase_nxt = smft_pkg::PH_IDLE;
        done      = 1'b1;
      end
    endcase
  end

  always_comb begin
    result.chip_select_n = (phase_nxt == smft_pkg::PH_IDLE);
    result.serial_clock  = (phase_nxt == smft_pkg::PH_DATA) & sck_nxt;
    result.mosi_bit      = (phase_nxt == smft_pkg::PH_DATA) & tx_nxt[FRAME_BITS-1];
    result.ready_res     = (phase_nxt == smft_pkg::PH_IDLE);
    result.read_data     = smft_pkg::RD_W'(rx_nxt);
    result.done_res      = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= smft_pkg::HALF_PERIOD_RST;
      phase_r       <= smft_pkg::PH_IDLE;
      div_r         <= '0;
      sck_r         <= 1'b0;
      tx_r          <= '0;
      bit_idx_r     <= '0;
      rx_r          <= '0;
    end else begin
      if (cfg_write_en) begin
        half_period_r <= cfg_write_data;
      end
      if (step) begin
        phase_r   <= phase_nxt;
        div_r     <= div_nxt;
        sck_r     <= sck_nxt;
        tx_r      <= tx_nxt;
        bit_idx_r <= bit_idx_nxt;
        rx_r      <= rx_nxt;
      end
    end
  end

endmodule

// ===== rtl/spi_master_frame_transfer.sv =====
// Channel  Ports                            Word
// input    in_valid, in_stall, in_word      start_req, command, address, write_data, miso_bit
// result   out_valid, out_stall, out_word   chip_select_n, serial_clock, mosi_bit,
//                                           ready_res, read_data, done_res
// config   cfg_write_en, cfg_write_data     half_period_cycles
//
// One word in, one registered word out; a new word every cycle while in_stall is low.
// The serial state advances once per accepted word, in the same cycle.
// Results pass through a two-entry output buffer; in_stall rises only when both are full.
// Synchronous reset clears the serial state, sets half_period_cycles to 5 and empties
// the buffer.
module spi_master_frame_transfer #(
  parameter int FRAME_BITS   = smft_pkg::FRAME_BITS_DEF,
  parameter int READ_BITS    = smft_pkg::READ_BITS_DEF,
  parameter int ADDRESS_BITS = smft_pkg::ADDRESS_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  smft_pkg::in_word_t         in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output smft_pkg::out_word_t        out_word,
  input  logic                       cfg_write_en,
  input  logic [smft_pkg::DIV_W-1:0] cfg_write_data
);

  logic                push;
  logic                pop;
  smft_pkg::out_word_t result;

  logic                head_valid_r;
  smft_pkg::out_word_t head_r;
  logic                skid_valid_r;
  smft_pkg::out_word_t skid_r;

  assign in_stall  = skid_valid_r;
  assign push      = in_valid & ~skid_valid_r;
  assign pop       = head_valid_r & ~out_stall;
  assign out_valid = head_valid_r;
  assign out_word  = head_r;

  smft_core #(
    .FRAME_BITS  (FRAME_BITS),
    .READ_BITS   (READ_BITS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .step          (push),
    .in_word       (in_word),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop || !head_valid_r) begin
        head_valid_r <= skid_valid_r | push;
        skid_valid_r <= 1'b0;
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !head_valid_r) begin
      head_r <= skid_valid_r ? skid_r : result;
    end else if (push) begin
      skid_r <= result;
    end
  end

endmodule
